FILE: sv/gap_buffer_line_editor_unit_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the gap buffer line editor
// Concurrent checks sampled on clk and disabled while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef GAP_BUFFER_LINE_EDITOR_UNIT_ASSERT_SVH
`define GAP_BUFFER_LINE_EDITOR_UNIT_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define GBLE_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define GBLE_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: sv/gble_pkg.sv
// ----------------------------------------------------------------------------
// gble_pkg
// Shared constants, codes and types of the gap buffer line editor.
// ----------------------------------------------------------------------------
package gble_pkg;

	// Store size and the widths that follow from it.
	localparam int CAPACITY = 4096;
	localparam int ADDR_W   = $clog2(CAPACITY);
	localparam int CNT_W    = ADDR_W + 1;

	// Fixed field widths of the requests and results.
	localparam int OP_W     = 3;
	localparam int CHAR_W   = 8;
	localparam int IDX_W    = 12;
	localparam int LEN_W    = 13;
	localparam int STAT_W   = 2;

	localparam logic [CNT_W-1:0] CAP_C = CNT_W'(CAPACITY);

	// Command codes; the remaining codes do nothing.
	typedef enum logic [OP_W-1:0] {
		OP_LEFT   = 3'd0,
		OP_RIGHT  = 3'd1,
		OP_BACK   = 3'd2,
		OP_INSERT = 3'd3,
		OP_READ   = 3'd4
	} op_t;

	// Result status codes.
	typedef enum logic [STAT_W-1:0] {
		STAT_DONE     = 2'd0,
		STAT_BOUNDARY = 2'd1,
		STAT_FULL     = 2'd2
	} status_t;

	// Controller states.
	typedef enum logic {
		S_IDLE,
		S_MEM
	} state_t;

	// Memory access issued by the controller.
	typedef struct packed {
		logic              we;
		logic [ADDR_W-1:0] waddr;
		logic [CHAR_W-1:0] wdata;
		logic              re;
		logic [ADDR_W-1:0] raddr;
	} mem_req_t;

endpackage

FILE: sv/gble_cmd_if.sv
// ----------------------------------------------------------------------------
// gble_cmd_if
// Command channel: one editing request per handshake.
// ----------------------------------------------------------------------------
interface gble_cmd_if;
	logic                        valid;
	logic                        ready;
	logic [gble_pkg::OP_W-1:0]   operation;
	logic [gble_pkg::CHAR_W-1:0] char_in;
	logic [gble_pkg::IDX_W-1:0]  read_index;

	modport source (output valid, operation, char_in, read_index, input ready);
	modport sink   (input valid, operation, char_in, read_index, output ready);
endinterface

FILE: sv/gble_res_if.sv
// ----------------------------------------------------------------------------
// gble_res_if
// Result channel: one result per command request.
// ----------------------------------------------------------------------------
interface gble_res_if;
	logic                        valid;
	logic                        ready;
	logic [gble_pkg::CHAR_W-1:0] char_out;
	logic [gble_pkg::LEN_W-1:0]  text_length;
	logic [gble_pkg::LEN_W-1:0]  cursor_pos;
	logic [gble_pkg::STAT_W-1:0] status;

	modport source (output valid, char_out, text_length, cursor_pos, status, input ready);
	modport sink   (input valid, char_out, text_length, cursor_pos, status, output ready);
endinterface

FILE: sv/gble_ram.sv
// ----------------------------------------------------------------------------
// gble_ram
// Simple dual-port synchronous RAM: one write and one registered read port.
// ----------------------------------------------------------------------------
module gble_ram #(
	parameter int DEPTH = 4096,
	parameter int WIDTH = 8
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Registered read port.
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

FILE: sv/gble_ctrl.sv
// ----------------------------------------------------------------------------
// gble_ctrl
// Cursor and length bookkeeping, command decode, memory sequencing and the
// result register of the gap buffer line editor.
// ----------------------------------------------------------------------------
module gble_ctrl (
	input  logic                        clk,
	input  logic                        arst_n,
	gble_cmd_if.sink                    cmd,
	gble_res_if.source                  res,
	output gble_pkg::mem_req_t          mem_req,
	input  logic [gble_pkg::CHAR_W-1:0] mem_rdata
);

	gble_pkg::state_t state_q, state_n;

	logic [gble_pkg::CNT_W-1:0]  lc_q, rc_q, lc_n, rc_n;
	logic [gble_pkg::CNT_W-1:0]  len_c, idx_c;
	logic [gble_pkg::OP_W-1:0]   op_q;
	logic                        acc;
	logic                        out_free;
	logic                        needs_read;
	logic                        load_res;
	logic [gble_pkg::CHAR_W-1:0] char_c;
	gble_pkg::status_t           status_c;

	logic                        res_valid_q;
	logic [gble_pkg::CHAR_W-1:0] char_q;
	logic [gble_pkg::CNT_W-1:0]  len_q, cur_q;
	logic [gble_pkg::STAT_W-1:0] status_q;

	assign acc      = cmd.valid && cmd.ready;
	assign out_free = !res_valid_q || res.ready;
	assign len_c    = lc_q + rc_q;
	assign idx_c    = gble_pkg::CNT_W'(cmd.read_index);

	// Next state: memory commands wait in S_MEM for the read data.
	always_comb begin
		state_n = state_q;
		case (state_q)
			gble_pkg::S_IDLE: begin
				if (acc && needs_read) begin
					state_n = gble_pkg::S_MEM;
				end
			end
			gble_pkg::S_MEM: begin
				state_n = gble_pkg::S_IDLE;
			end
			default: begin
				state_n = gble_pkg::S_IDLE;
			end
		endcase
	end

	// Outputs of the state machine: a request is taken only when idle and
	// the result register will be free to receive its answer.
	always_comb begin
		case (state_q)
			gble_pkg::S_IDLE: cmd.ready = out_free;
			default:          cmd.ready = 1'b0;
		endcase
	end

	// Command decode and the memory access of each cycle.
	always_comb begin
		lc_n       = lc_q;
		rc_n       = rc_q;
		needs_read = 1'b0;
		char_c     = '0;
		status_c   = gble_pkg::STAT_DONE;
		mem_req    = '0;
		if (state_q == gble_pkg::S_MEM) begin
			// Second half of a move or a read: the fetched character is ready.
			case (op_q)
				gble_pkg::OP_LEFT: begin
					mem_req.we    = 1'b1;
					mem_req.waddr = gble_pkg::ADDR_W'(gble_pkg::CAP_C - rc_q - 1'b1);
					mem_req.wdata = mem_rdata;
					lc_n          = lc_q - 1'b1;
					rc_n          = rc_q + 1'b1;
				end
				gble_pkg::OP_RIGHT: begin
					mem_req.we    = 1'b1;
					mem_req.waddr = gble_pkg::ADDR_W'(lc_q);
					mem_req.wdata = mem_rdata;
					lc_n          = lc_q + 1'b1;
					rc_n          = rc_q - 1'b1;
				end
				gble_pkg::OP_READ: begin
					char_c = mem_rdata;
				end
				default: begin
					char_c = '0;
				end
			endcase
		end else if (acc) begin
			case (cmd.operation)
				gble_pkg::OP_LEFT: begin
					if (lc_q == '0) begin
						status_c = gble_pkg::STAT_BOUNDARY;
					end else begin
						needs_read    = 1'b1;
						mem_req.re    = 1'b1;
						mem_req.raddr = gble_pkg::ADDR_W'(lc_q - 1'b1);
					end
				end
				gble_pkg::OP_RIGHT: begin
					if (rc_q == '0) begin
						status_c = gble_pkg::STAT_BOUNDARY;
					end else begin
						needs_read    = 1'b1;
						mem_req.re    = 1'b1;
						mem_req.raddr = gble_pkg::ADDR_W'(gble_pkg::CAP_C - rc_q);
					end
				end
				gble_pkg::OP_BACK: begin
					if (lc_q == '0) begin
						status_c = gble_pkg::STAT_BOUNDARY;
					end else begin
						lc_n = lc_q - 1'b1;
					end
				end
				gble_pkg::OP_INSERT: begin
					if (len_c >= gble_pkg::CAP_C) begin
						status_c = gble_pkg::STAT_FULL;
					end else begin
						mem_req.we    = 1'b1;
						mem_req.waddr = gble_pkg::ADDR_W'(lc_q);
						mem_req.wdata = cmd.char_in;
						lc_n          = lc_q + 1'b1;
					end
				end
				gble_pkg::OP_READ: begin
					if (idx_c >= len_c) begin
						status_c = gble_pkg::STAT_FULL;
					end else begin
						needs_read = 1'b1;
						mem_req.re = 1'b1;
						// Text right of the cursor sits above the gap.
						if (idx_c < lc_q) begin
							mem_req.raddr = gble_pkg::ADDR_W'(idx_c);
						end else begin
							mem_req.raddr = gble_pkg::ADDR_W'(idx_c + gble_pkg::CAP_C - len_c);
						end
					end
				end
				default: begin
					status_c = gble_pkg::STAT_DONE;
				end
			endcase
		end
	end

	assign load_res = (acc && !needs_read) || (state_q == gble_pkg::S_MEM);

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= gble_pkg::S_IDLE;
			lc_q        <= '0;
			rc_q        <= '0;
			res_valid_q <= 1'b0;
		end else begin
			state_q <= state_n;
			lc_q    <= lc_n;
			rc_q    <= rc_n;
			if (load_res) begin
				res_valid_q <= 1'b1;
			end else if (res.ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	// Command and result payload registers.
	always_ff @(posedge clk) begin
		if (acc) begin
			op_q <= cmd.operation;
		end
		if (load_res) begin
			char_q   <= char_c;
			len_q    <= lc_n + rc_n;
			cur_q    <= lc_n;
			status_q <= status_c;
		end
	end

	assign res.valid       = res_valid_q;
	assign res.char_out    = char_q;
	assign res.text_length = gble_pkg::LEN_W'(len_q);
	assign res.cursor_pos  = gble_pkg::LEN_W'(cur_q);
	assign res.status      = status_q;

	`include "gap_buffer_line_editor_unit_assert.svh"

	// The text never outgrows the store.
	`GBLE_ASSERT_NOW(a_len_bound, 1'b1, ({1'b0, lc_q} + {1'b0, rc_q}) <= {1'b0, gble_pkg::CAP_C}, "text length exceeds capacity")
	// No new request is taken while read data is pending.
	`GBLE_ASSERT_NOW(a_no_accept_mem, state_q == gble_pkg::S_MEM, !cmd.ready, "request accepted during memory cycle")
	// A memory command produces no result until its data returns.
	`GBLE_ASSERT_NEXT(a_mem_seq, acc && needs_read, state_q == gble_pkg::S_MEM && !res_valid_q, "memory command sequencing broken")
	// A completed left move shifts one character across the gap.
	`GBLE_ASSERT_NEXT(a_left_move, state_q == gble_pkg::S_MEM && op_q == gble_pkg::OP_LEFT, rc_q == $past(rc_q) + 1'b1, "left move did not grow right side")

endmodule

FILE: sv/gap_buffer_line_editor_unit.sv
// ----------------------------------------------------------------------------
// gap_buffer_line_editor_unit
// Text line editor with a cursor, held as a gap buffer in one RAM.
// Backspace, insert, rejected and unknown commands load the result register
// as they are accepted; moves and successful reads first read the text RAM
// through its registered read port, then write back or capture in S_MEM.
// Commands are taken one at a time, and not while a result is held unread.
// Reset: cursor and length clear to zero; the RAM contents are not cleared.
// ----------------------------------------------------------------------------
module gap_buffer_line_editor_unit (
	input  logic       clk,
	input  logic       arst_n,
	gble_cmd_if.sink   cmd,
	gble_res_if.source res
);

	gble_pkg::mem_req_t          mem_req;
	logic [gble_pkg::CHAR_W-1:0] mem_rdata;

	// Command sequencing and bookkeeping.
	gble_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.res       (res),
		.mem_req   (mem_req),
		.mem_rdata (mem_rdata)
	);

	// Text store.
	gble_ram #(
		.DEPTH (gble_pkg::CAPACITY),
		.WIDTH (gble_pkg::CHAR_W)
	) u_ram (
		.clk   (clk),
		.we    (mem_req.we),
		.waddr (mem_req.waddr),
		.wdata (mem_req.wdata),
		.re    (mem_req.re),
		.raddr (mem_req.raddr),
		.rdata (mem_rdata)
	);

endmodule

FILE: sim/tb_gap_buffer_line_editor_unit.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_gap_buffer_line_editor_unit
// Self-checking bench for the gap buffer line editor. A short scripted run
// covers the boundaries and the rejected commands. Random editing follows,
// first with stalls and then without. Typed script rows are checked against
// their own results, the rest against a behavioural copy kept in the bench.
// ----------------------------------------------------------------------------
module tb_gap_buffer_line_editor_unit;

	// Command codes that the editor treats as no operation.
	localparam logic [gble_pkg::OP_W-1:0] OP_SPARE_LO  = 3'd5;
	localparam logic [gble_pkg::OP_W-1:0] OP_SPARE_MID = 3'd6;
	localparam logic [gble_pkg::OP_W-1:0] OP_SPARE_HI  = 3'd7;

	localparam int MIXED_EDITS    = 500;
	localparam int STEADY_EDITS   = 300;
	localparam int CLOSING_EDITS  = 350;
	localparam int HOLD_CYCLES    = 60;
	localparam int DRAIN_CYCLES   = 8;
	localparam int WATCHDOG_LIMIT = 1000;

	typedef struct packed {
		logic [gble_pkg::OP_W-1:0]   op;
		logic [gble_pkg::CHAR_W-1:0] ch;
		logic [gble_pkg::IDX_W-1:0]  idx;
	} edit_req_t;

	typedef struct packed {
		logic [gble_pkg::CHAR_W-1:0] char_out;
		logic [gble_pkg::LEN_W-1:0]  text_length;
		logic [gble_pkg::LEN_W-1:0]  cursor_pos;
		logic [gble_pkg::STAT_W-1:0] status;
	} edit_res_t;

	typedef struct packed {
		edit_req_t rq;
		logic      typed;
		edit_res_t res;
	} script_row_t;

	logic clk;
	logic arst_n;

	gble_cmd_if cmd_ch ();
	gble_res_if res_ch ();

	gap_buffer_line_editor_unit dut (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd_ch),
		.res    (res_ch)
	);

	// Shadow of the editor: text store and the two counts either side of the gap.
	logic [gble_pkg::CHAR_W-1:0] text_mem [gble_pkg::CAPACITY];
	int unsigned       left_n       = 0;
	int unsigned       right_n      = 0;

	edit_res_t         expected_q [$];
	script_row_t       script_q [$];
	int unsigned       fail_count   = 0;
	int unsigned       quiet_cycles = 0;
	bit                idle_enable  = 1'b0;
	bit                hold_results = 1'b0;

	// 4 ns clock.
	always begin
		clk = 1'b0;
		#2;
		clk = 1'b1;
		#2;
	end

	// Applies one command to the shadow editor and returns the result it gives.
	function automatic edit_res_t apply_edit(edit_req_t rq);
		edit_res_t   r;
		int unsigned len;
		r = '0;
		r.status = gble_pkg::STAT_DONE;
		case (rq.op)
			gble_pkg::OP_LEFT: begin
				if (left_n == 0) begin
					r.status = gble_pkg::STAT_BOUNDARY;
				end else begin
					left_n--;
					text_mem[gble_pkg::CAPACITY - right_n - 1] = text_mem[left_n];
					right_n++;
				end
			end
			gble_pkg::OP_RIGHT: begin
				if (right_n == 0) begin
					r.status = gble_pkg::STAT_BOUNDARY;
				end else begin
					text_mem[left_n] = text_mem[gble_pkg::CAPACITY - right_n];
					left_n++;
					right_n--;
				end
			end
			gble_pkg::OP_BACK: begin
				if (left_n == 0)
					r.status = gble_pkg::STAT_BOUNDARY;
				else
					left_n--;
			end
			gble_pkg::OP_INSERT: begin
				if (left_n + right_n >= gble_pkg::CAPACITY) begin
					r.status = gble_pkg::STAT_FULL;
				end else begin
					text_mem[left_n] = rq.ch;
					left_n++;
				end
			end
			gble_pkg::OP_READ: begin
				len = left_n + right_n;
				if (rq.idx >= len)
					r.status = gble_pkg::STAT_FULL;
				else if (rq.idx < left_n)
					r.char_out = text_mem[rq.idx];
				else
					r.char_out = text_mem[gble_pkg::CAPACITY - right_n + (rq.idx - left_n)];
			end
			default: ;
		endcase
		r.text_length = gble_pkg::LEN_W'(left_n + right_n);
		r.cursor_pos  = gble_pkg::LEN_W'(left_n);
		return r;
	endfunction

	// Draws a random command, weighted towards edits and reads within the text.
	function automatic edit_req_t draw_edit();
		edit_req_t   rq;
		int unsigned pick;
		int unsigned len;
		len    = left_n + right_n;
		rq.ch  = gble_pkg::CHAR_W'($urandom_range(0, 255));
		rq.idx = gble_pkg::IDX_W'($urandom_range(0, 4095));
		pick   = $urandom_range(0, 99);
		if (pick < 35) begin
			rq.op = gble_pkg::OP_INSERT;
		end else if (pick < 50) begin
			rq.op = gble_pkg::OP_LEFT;
		end else if (pick < 65) begin
			rq.op = gble_pkg::OP_RIGHT;
		end else if (pick < 75) begin
			rq.op = gble_pkg::OP_BACK;
		end else if (pick < 95) begin
			rq.op = gble_pkg::OP_READ;
			// Mostly positions within the text, the end position included.
			if (len > 0 && $urandom_range(0, 3) != 0)
				rq.idx = gble_pkg::IDX_W'($urandom_range(0, (len > 4095) ? 4095 : len));
		end else begin
			rq.op = gble_pkg::OP_W'($urandom_range(OP_SPARE_LO, OP_SPARE_HI));
		end
		return rq;
	endfunction

	function automatic void compare_field(string name, int unsigned want, int unsigned got);
		if (want != got) begin
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
			fail_count++;
		end
	endfunction

	task automatic add_row(input logic [gble_pkg::OP_W-1:0] op,
			input logic [gble_pkg::CHAR_W-1:0] ch, input logic [gble_pkg::IDX_W-1:0] idx,
			input logic typed, input int unsigned c, input int unsigned l,
			input int unsigned p, input logic [gble_pkg::STAT_W-1:0] s);
		script_row_t row;
		row.rq    = '{op: op, ch: ch, idx: idx};
		row.typed = typed;
		row.res   = '{char_out: gble_pkg::CHAR_W'(c), text_length: gble_pkg::LEN_W'(l),
			cursor_pos: gble_pkg::LEN_W'(p), status: s};
		script_q  = {script_q, row};
	endtask

	// Offers one request, waits for it to be taken and records the result it is due.
	task automatic submit_edit(input edit_req_t rq, input logic typed, input edit_res_t typed_res);
		edit_res_t predicted;
		edit_res_t due;
		if (idle_enable && $urandom_range(0, 4) == 0) begin
			cmd_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 7)) @(posedge clk);
		end
		cmd_ch.valid      <= 1'b1;
		cmd_ch.operation  <= rq.op;
		cmd_ch.char_in    <= rq.ch;
		cmd_ch.read_index <= rq.idx;
		@(posedge clk);
		while (!cmd_ch.ready)
			@(posedge clk);
		predicted  = apply_edit(rq);
		due        = typed ? typed_res : predicted;
		expected_q = {expected_q, due};
	endtask

	// Stops offering requests until every outstanding result has come back.
	task automatic drain_results();
		cmd_ch.valid <= 1'b0;
		@(posedge clk);
		while (expected_q.size() != 0)
			@(posedge clk);
		@(posedge clk);
	endtask

	// Result side: random stalls, plus one long hold-off on request.
	initial begin : result_sink
		res_ch.ready <= 1'b0;
		wait (arst_n);
		@(posedge clk);
		forever begin
			if (hold_results) begin
				res_ch.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_results = 1'b0;
			end else if (idle_enable && $urandom_range(0, 5) == 0) begin
				res_ch.ready <= 1'b0;
				repeat ($urandom_range(1, 7)) @(posedge clk);
			end else begin
				res_ch.ready <= 1'b1;
				@(posedge clk);
			end
		end
	end

	// Compare each returned result with the oldest expectation.
	always @(posedge clk) begin : result_check
		edit_res_t want;
		if (arst_n && res_ch.valid && res_ch.ready) begin
			if (expected_q.size() == 0) begin
				$display("%0t: unexpected result, expected none, actual char %0d length %0d cursor %0d status %0d",
					$time, res_ch.char_out, res_ch.text_length, res_ch.cursor_pos, res_ch.status);
				fail_count++;
			end else begin
				want = expected_q.pop_front();
				compare_field("char_out", want.char_out, res_ch.char_out);
				compare_field("text_length", want.text_length, res_ch.text_length);
				compare_field("cursor_pos", want.cursor_pos, res_ch.cursor_pos);
				compare_field("status", want.status, res_ch.status);
			end
		end
	end

	// Watchdog on cycles in which neither channel moves a request.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((cmd_ch.valid && cmd_ch.ready) || (res_ch.valid && res_ch.ready))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("tb: failure");
				$finish;
			end
		end
	end

	initial begin : stimulus
		arst_n = 1'b0;
		cmd_ch.valid      <= 1'b0;
		cmd_ch.operation  <= gble_pkg::OP_LEFT;
		cmd_ch.char_in    <= '0;
		cmd_ch.read_index <= '0;

		// Boundaries on the empty line, no-op codes, then a short edit around the cursor.
		add_row(gble_pkg::OP_LEFT, 8'h00, 12'h000, 1'b1, 0, 0, 0, gble_pkg::STAT_BOUNDARY);
		add_row(gble_pkg::OP_RIGHT, 8'hFF, 12'hFFF, 1'b1, 0, 0, 0, gble_pkg::STAT_BOUNDARY);
		add_row(gble_pkg::OP_BACK, 8'h00, 12'h000, 1'b1, 0, 0, 0, gble_pkg::STAT_BOUNDARY);
		add_row(gble_pkg::OP_READ, 8'h00, 12'h000, 1'b1, 0, 0, 0, gble_pkg::STAT_FULL);
		add_row(gble_pkg::OP_READ, 8'hFF, 12'hFFF, 1'b1, 0, 0, 0, gble_pkg::STAT_FULL);
		add_row(OP_SPARE_LO, 8'hFF, 12'hFFF, 1'b1, 0, 0, 0, gble_pkg::STAT_DONE);
		add_row(OP_SPARE_MID, 8'h5A, 12'hA5A, 1'b1, 0, 0, 0, gble_pkg::STAT_DONE);
		add_row(OP_SPARE_HI, 8'h00, 12'h000, 1'b1, 0, 0, 0, gble_pkg::STAT_DONE);
		add_row(gble_pkg::OP_INSERT, 8'h00, 12'h000, 1'b1, 0, 1, 1, gble_pkg::STAT_DONE);
		add_row(gble_pkg::OP_INSERT, 8'hFF, 12'hFFF, 1'b1, 0, 2, 2, gble_pkg::STAT_DONE);
		add_row(gble_pkg::OP_INSERT, "L", 12'h000, 1'b1, 0, 3, 3, gble_pkg::STAT_DONE);
		add_row(gble_pkg::OP_READ, 8'h00, 12'd1, 1'b1, 8'hFF, 3, 3, gble_pkg::STAT_DONE);
		add_row(gble_pkg::OP_READ, 8'h00, 12'd3, 1'b1, 0, 3, 3, gble_pkg::STAT_FULL);
		add_row(gble_pkg::OP_LEFT, 8'h00, 12'h000, 1'b0, 0, 0, 0, gble_pkg::STAT_DONE);
		add_row(gble_pkg::OP_LEFT, 8'h00, 12'h000, 1'b0, 0, 0, 0, gble_pkg::STAT_DONE);
		add_row(gble_pkg::OP_READ, 8'h00, 12'd0, 1'b0, 0, 0, 0, gble_pkg::STAT_DONE);
		add_row(gble_pkg::OP_READ, 8'h00, 12'd2, 1'b0, 0, 0, 0, gble_pkg::STAT_DONE);
		add_row(gble_pkg::OP_INSERT, "D", 12'h000, 1'b0, 0, 0, 0, gble_pkg::STAT_DONE);
		add_row(gble_pkg::OP_RIGHT, 8'h00, 12'h000, 1'b0, 0, 0, 0, gble_pkg::STAT_DONE);
		add_row(gble_pkg::OP_BACK, 8'h00, 12'h000, 1'b0, 0, 0, 0, gble_pkg::STAT_DONE);
		add_row(gble_pkg::OP_INSERT, "B", 12'h000, 1'b0, 0, 0, 0, gble_pkg::STAT_DONE);
		add_row(gble_pkg::OP_RIGHT, 8'h00, 12'h000, 1'b0, 0, 0, 0, gble_pkg::STAT_DONE);
		add_row(gble_pkg::OP_RIGHT, 8'h00, 12'h000, 1'b0, 0, 0, 0, gble_pkg::STAT_DONE);
		add_row(gble_pkg::OP_INSERT, "P", 12'h000, 1'b0, 0, 0, 0, gble_pkg::STAT_DONE);
		add_row(gble_pkg::OP_READ, 8'h00, 12'd4, 1'b0, 0, 0, 0, gble_pkg::STAT_DONE);

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Scripted requests.
		idle_enable = 1'b1;
		foreach (script_q[i])
			submit_edit(script_q[i].rq, script_q[i].typed, script_q[i].res);

		// Random editing with stalls; one long result hold-off and one full drain.
		for (int n = 0; n < MIXED_EDITS; n++) begin
			if (n == 200)
				hold_results = 1'b1;
			if (n == 350)
				drain_results();
			submit_edit(draw_edit(), 1'b0, '0);
		end

		// Back-to-back random editing.
		idle_enable = 1'b0;
		for (int n = 0; n < STEADY_EDITS; n++)
			submit_edit(draw_edit(), 1'b0, '0);

		// Closing stretch without any stalls.
		drain_results();
		idle_enable = 1'b0;
		for (int n = 0; n < CLOSING_EDITS; n++)
			submit_edit(draw_edit(), 1'b0, '0);

		drain_results();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
